[hw/rtl/kbil_pkg.sv]
// Shared types, codes and constants for the k-mer bucket index lookup.
// Used by the controller, the datapath and the top level; no dependencies.
package kbil_pkg;

  // Fixed field widths.
  localparam int KW        = 125;
  localparam int UPPER_W   = 61;
  localparam int LOWER_W   = 64;
  localparam int OFF_W     = 17;

  // Parameter defaults.
  localparam int MAX_LEN_DEF     = 25;
  localparam int KEY_DEPTH_DEF   = 65536;
  localparam int BUCKET_BITS_DEF = 10;

  // Operation codes of an input item.
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_BUCKET = 2'd1;
  localparam logic [1:0] OP_BUILT  = 2'd2;
  localparam logic [1:0] OP_TAG    = 2'd3;

  // Result codes.
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_FWD  = 2'd1;
  localparam logic [1:0] HIT_REV  = 2'd2;

  // Characters.
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_Z = 8'h5A;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_BKT0, S_BKT1, S_BKT2, S_LOOP, S_CMP, S_FIN, S_FCMP, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_en;
    logic       calc;
    logic       bkt_rd;
    logic       bkt_rd_next;
    logic       cap_start;
    logic       cap_end;
    logic       mid_rd;
    logic       upd;
    logic       fin_rd;
    logic       use_rev;
    logic       out_load;
    logic [1:0] out_hit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;
    logic eligible;
    logic lo_lt_hi;
    logic lo_lt_end;
    logic key_eq;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/kbil_ctrl.sv]
// Lookup sequencer: steps the bucket reads and the binary search.
// Depends on kbil_pkg for the state, command and status types.
module kbil_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             both_strands,
  input  kbil_pkg::status_t st,
  output kbil_pkg::cmd_t    cmd
);
  import kbil_pkg::*;

  state_t     state, state_next;
  logic       rev, rev_next;
  logic [1:0] res, res_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rev   <= 1'b0;
      res   <= HIT_NONE;
    end else begin
      state <= state_next;
      rev   <= rev_next;
      res   <= res_next;
    end
  end

  // Next state; a miss retries with the reversed key when enabled.
  always_comb begin
    state_next = state;
    rev_next   = rev;
    res_next   = res;
    case (state)
      S_IDLE: begin
        rev_next = 1'b0;
        if (st.start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.eligible) begin
          state_next = S_BKT0;
        end else begin
          res_next   = HIT_NONE;
          state_next = S_DONE;
        end
      end
      S_BKT0: state_next = S_BKT1;
      S_BKT1: state_next = S_BKT2;
      S_BKT2: state_next = S_LOOP;
      S_LOOP: state_next = st.lo_lt_hi ? S_CMP : S_FIN;
      S_CMP:  state_next = S_LOOP;
      S_FIN: begin
        if (st.lo_lt_end) begin
          state_next = S_FCMP;
        end else if (!rev && both_strands) begin
          rev_next   = 1'b1;
          state_next = S_CHECK;
        end else begin
          res_next   = HIT_NONE;
          state_next = S_DONE;
        end
      end
      S_FCMP: begin
        if (st.key_eq) begin
          res_next   = rev ? HIT_REV : HIT_FWD;
          state_next = S_DONE;
        end else if (!rev && both_strands) begin
          rev_next   = 1'b1;
          state_next = S_CHECK;
        end else begin
          res_next   = HIT_NONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd          = '0;
    cmd.use_rev  = rev;
    cmd.out_hit  = res;
    case (state)
      S_IDLE: cmd.in_en       = 1'b1;
      S_CHECK: cmd.calc       = 1'b1;
      S_BKT0: cmd.bkt_rd      = 1'b1;
      S_BKT1: begin
        cmd.bkt_rd_next = 1'b1;
        cmd.cap_start   = 1'b1;
      end
      S_BKT2: cmd.cap_end     = 1'b1;
      S_LOOP: cmd.mid_rd      = st.lo_lt_hi;
      S_CMP:  cmd.upd         = 1'b1;
      S_FIN:  cmd.fin_rd      = st.lo_lt_end;
      S_DONE: cmd.out_load    = st.out_free;
      default: cmd.in_en      = 1'b0;
    endcase
  end

endmodule

[hw/rtl/kbil_dp.sv]
// Datapath: key and bucket memories, tag packing, search pointers, result register.
// Depends on kbil_pkg; driven by kbil_ctrl through command and status structs.
module kbil_dp #(
  parameter int MAX_LEN     = kbil_pkg::MAX_LEN_DEF,
  parameter int KEY_DEPTH   = kbil_pkg::KEY_DEPTH_DEF,
  parameter int BUCKET_BITS = kbil_pkg::BUCKET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  kbil_pkg::cmd_t    cmd,
  output kbil_pkg::status_t st,
  input  logic [4:0]        minimum_length,
  input  logic              in_valid,
  input  logic [1:0]        operation,
  input  logic [15:0]       key_slot,
  input  logic [60:0]       key_upper,
  input  logic [63:0]       key_lower,
  input  logic [4:0]        key_length,
  input  logic [10:0]       bucket_index,
  input  logic [16:0]       bucket_start,
  input  logic              built_flag,
  input  logic [7:0]        tag_byte,
  input  logic              tag_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        hit
);
  import kbil_pkg::*;

  localparam int KA     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int NBUCK  = (1 << BUCKET_BITS) + 1;
  localparam int BDEPTH = MAX_LEN * NBUCK;
  localparam int BA     = $clog2(BDEPTH);
  localparam int PW     = (KA + 1 > OFF_W) ? KA + 1 : OFF_W;
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int LW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic accept;
  assign accept = in_valid & cmd.in_en;

  // Key store, one read port with registered data.
  logic [KW-1:0] kmem [KEY_DEPTH];
  logic [KW-1:0] kq;
  logic [KA-1:0] kaddr;
  logic          key_wr;
  logic [PW-1:0] lo, hi, endv, mid, mid_next;
  logic [PW:0]   mid_sum;

  assign key_wr   = accept && operation == OP_KEY && 32'(key_slot) < KEY_DEPTH;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_next = mid_sum[PW:1];
  assign kaddr    = cmd.mid_rd ? mid_next[KA-1:0] : lo[KA-1:0];

  always_ff @(posedge clk) begin
    if (key_wr) kmem[KA'(key_slot)] <= {key_upper, key_lower};
    if (cmd.mid_rd || cmd.fin_rd) kq <= kmem[kaddr];
  end

  // Bucket offset store.
  logic [OFF_W-1:0] bmem [BDEPTH];
  logic [OFF_W-1:0] bq;
  logic [BA-1:0]    bwa, baddr, baddr_next, braddr;
  logic             bkt_wr;

  assign bkt_wr = accept && operation == OP_BUCKET && key_length != 5'd0 &&
                  32'(key_length) <= MAX_LEN && 32'(bucket_index) < NBUCK;
  assign bwa    = BA'(32'(key_length - 5'd1) * NBUCK + 32'(bucket_index));
  assign braddr = cmd.bkt_rd ? baddr : baddr + BA'(1);

  always_ff @(posedge clk) begin
    if (bkt_wr) bmem[bwa] <= bucket_start;
    if (cmd.bkt_rd || cmd.bkt_rd_next) bq <= bmem[braddr];
  end

  // Built flags per length.
  logic [MAX_LEN-1:0] ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else if (accept && operation == OP_BUILT && key_length != 5'd0 &&
                 32'(key_length) <= MAX_LEN) begin
      ready[LW'(key_length - 5'd1)] <= built_flag;
    end
  end

  // Tag packing: forward key shifts in, reversed key ORs at the letter position.
  logic [KW-1:0] fwd, rev, fwd_n, rev_n, kf, kr;
  logic [CW-1:0] cnt, cnt_n, klen;
  logic          ovl, bad, ovl_n, bad_n, ovl_s, bad_s;
  logic [7:0]    ch;
  logic [4:0]    code;
  logic [6:0]    pos;
  logic          tag_acc, start;

  assign ch      = (tag_byte == CH_I) ? CH_L : tag_byte;
  assign code    = 5'(ch - CH_A);
  assign pos     = 7'(cnt) * 7'd5;
  assign tag_acc = accept && operation == OP_TAG;
  assign start   = tag_acc && tag_last;

  always_comb begin
    fwd_n = fwd;
    rev_n = rev;
    cnt_n = cnt;
    ovl_n = ovl;
    bad_n = bad;
    if (ovl || 32'(cnt) >= MAX_LEN) begin
      ovl_n = 1'b1;
    end else begin
      if (ch < CH_A || ch > CH_Z) begin
        bad_n = 1'b1;
      end else begin
        fwd_n = {fwd[KW-6:0], code};
        rev_n = rev | (KW'(code) << pos);
      end
      cnt_n = cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      rev <= '0;
      cnt <= '0;
      ovl <= 1'b0;
      bad <= 1'b0;
    end else if (start) begin
      fwd <= '0;
      rev <= '0;
      cnt <= '0;
      ovl <= 1'b0;
      bad <= 1'b0;
    end else if (tag_acc) begin
      fwd <= fwd_n;
      rev <= rev_n;
      cnt <= cnt_n;
      ovl <= ovl_n;
      bad <= bad_n;
    end
  end

  // Snapshot of the finished tag for the search.
  always_ff @(posedge clk) begin
    if (start) begin
      kf    <= fwd_n;
      kr    <= rev_n;
      klen  <= cnt_n;
      ovl_s <= ovl_n;
      bad_s <= bad_n;
    end
  end

  // Bucket address from the top bits of the selected key.
  logic [KW-1:0]          skey, shifted;
  logic [31:0]            kbits;
  logic [6:0]             sh;
  logic [BUCKET_BITS-1:0] bnum;

  assign skey    = cmd.use_rev ? kr : kf;
  assign kbits   = 32'(klen) * 32'd5;
  assign sh      = (kbits > BUCKET_BITS) ? 7'(kbits - BUCKET_BITS) : 7'd0;
  assign shifted = skey >> sh;
  assign bnum    = shifted[BUCKET_BITS-1:0];
  assign baddr_next = BA'(32'(klen - CW'(1)) * NBUCK + 32'(bnum));

  always_ff @(posedge clk) begin
    if (cmd.calc) baddr <= baddr_next;
  end

  // Search pointers.
  logic [PW-1:0] bq_w, end_cl;
  assign bq_w   = PW'(bq);
  assign end_cl = (bq_w > PW'(KEY_DEPTH)) ? PW'(KEY_DEPTH) : bq_w;

  always_ff @(posedge clk) begin
    if (cmd.cap_start) lo <= bq_w;
    if (cmd.cap_end) begin
      hi   <= end_cl;
      endv <= end_cl;
    end
    if (cmd.mid_rd) mid <= mid_next;
    if (cmd.upd) begin
      if (kq < skey) lo <= mid + PW'(1);
      else           hi <= mid;
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) hit <= cmd.out_hit;
  end

  // Status toward the controller.
  logic rdy_sel;
  assign rdy_sel = (klen != '0) && ready[LW'(klen - CW'(1))];

  assign st.start     = start;
  assign st.eligible  = !ovl_s && !bad_s && klen != '0 &&
                        32'(klen) >= 32'(minimum_length) && rdy_sel;
  assign st.lo_lt_hi  = lo < hi;
  assign st.lo_lt_end = lo < endv;
  assign st.key_eq    = kq == skey;
  assign st.out_free  = !(out_valid && out_stall);

endmodule

[hw/rtl/kmer_bucket_index_lookup_top.sv]
// Usage: software loads keys (operation 0), bucket start offsets (operation 1)
// and per-length built flags (operation 2) through the input channel, then
// streams query tags one byte per transfer (operation 3), tag_last on the
// final byte. Each final byte yields one transfer on the output channel with
// hit = 0 none, 1 forward match, 2 reversed match; other items yield nothing.
// Registers minimum_length (address 0) and both_strands (address 4) sit on
// the APB port; pready is always high.
// Sequencing: load items and non-final tag bytes are taken without a stall. A
// final byte holds in_stall high while the sequencer runs: the check in
// S_CHECK, the bucket offset reads in S_BKT0 to S_BKT2, binary search steps
// (a key store read in S_LOOP and a compare in S_CMP, about log2 of the
// bucket size + 1 steps), the loop exit in S_LOOP, the final key read in
// S_FIN and compare in S_FCMP, all repeated on a miss when the reversed key
// is also tried, then the result load in S_DONE. The key store has one read port.
// Reset (rst, synchronous) clears the tag state, built flags and registers;
// key and bucket stores hold garbage until written. While out_stall is high
// the result holds and further tag bytes are taken until the next final
// byte, whose search then waits to deliver.
module kmer_bucket_index_lookup_top #(
  parameter int MAX_LEN     = kbil_pkg::MAX_LEN_DEF,
  parameter int KEY_DEPTH   = kbil_pkg::KEY_DEPTH_DEF,
  parameter int BUCKET_BITS = kbil_pkg::BUCKET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] key_slot,
  input  logic [60:0] key_upper,
  input  logic [63:0] key_lower,
  input  logic [4:0]  key_length,
  input  logic [10:0] bucket_index,
  input  logic [16:0] bucket_start,
  input  logic        built_flag,
  input  logic [7:0]  tag_byte,
  input  logic        tag_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  hit
);
  import kbil_pkg::*;

  cmd_t       cmd;
  status_t    st;
  logic [4:0] minimum_length;
  logic       both_strands;
  logic       cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_length <= 5'd1;
      both_strands   <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) both_strands   <= pwdata[0];
      else          minimum_length <= pwdata[4:0];
    end
  end

  assign prdata = paddr[2] ? {31'd0, both_strands} : {27'd0, minimum_length};

  // Input is taken only while the sequencer is idle.
  assign in_stall = !cmd.in_en;

  kbil_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .both_strands (both_strands),
    .st           (st),
    .cmd          (cmd)
  );

  kbil_dp #(
    .MAX_LEN     (MAX_LEN),
    .KEY_DEPTH   (KEY_DEPTH),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .minimum_length (minimum_length),
    .in_valid       (in_valid),
    .operation      (operation),
    .key_slot       (key_slot),
    .key_upper      (key_upper),
    .key_lower      (key_lower),
    .key_length     (key_length),
    .bucket_index   (bucket_index),
    .bucket_start   (bucket_start),
    .built_flag     (built_flag),
    .tag_byte       (tag_byte),
    .tag_last       (tag_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit)
  );

`ifndef SYNTHESIS
  // A final tag byte starts a search, which stalls the input.
  a_start_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_TAG && tag_last) |=> in_stall)
    else $error("input not stalled after final tag byte");

  // A result load always presents a result.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  // A new result appears only from a load.
  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid rose without a result load");
`endif

endmodule
